@@ design/vpcp_pkg.sv @@
// shared types and constants for the video processor cpu port
`timescale 1ns / 1ps
`default_nettype none

package vpcp_pkg;

    typedef enum logic [2:0] {
        OP_DATA_WR   = 3'd0,
        OP_CTRL_WR   = 3'd1,
        OP_DATA_RD   = 3'd2,
        OP_STATUS_RD = 3'd3,
        OP_VBLANK    = 3'd4,
        OP_SPRITE    = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_FILL = 2'b10
    } t_state;

    localparam logic [7:0] REG_MASK [8] = '{
        8'h03, 8'hfb, 8'h0f, 8'hff, 8'h07, 8'h7f, 8'h07, 8'hff
    };

    localparam logic [2:0] IRQ_REG     = 3'd1;

    localparam int  STAT_VBLANK_BIT    = 7;
    localparam int  STAT_FIFTH_BIT     = 6;
    localparam int  STAT_COLLISION_BIT = 5;
    localparam int  IRQ_ENABLE_BIT     = 5;
    localparam logic [4:0] SPRITE_NONE = 5'd31;

endpackage

`default_nettype wire

@@ design/video_processor_cpu_port_top.sv @@
// top level of the video processor cpu port: vram, address latch, registers, status
// latency: result register loads at the accept edge, visible the next cycle
// throughput: one transaction every cycle unless the result is stalled; data reads
//   and control prefetches stall the port while the read-ahead byte refills
// reset: synchronous active low; address, latch, read-ahead byte, control registers
//   and status cleared, last sprite index set to 31; vram contents are not cleared
`timescale 1ns / 1ps
`default_nettype none

module video_processor_cpu_port_top #(
    parameter int VRAM_BYTES = 16384
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [2:0] i_operation,
    input  wire logic [7:0] i_data,
    input  wire logic       i_sprites_active,
    input  wire logic       i_collision,
    input  wire logic       i_fifth_found,
    input  wire logic [4:0] i_sprite_index,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_read_data,
    output logic            o_interrupt
);

    localparam int AW = $clog2(VRAM_BYTES);

    logic [7:0]          r_mem [VRAM_BYTES];
    logic [7:0]          r_mem_q;

    vpcp_pkg::t_state    r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic                r_pending, n_pending;
    logic [7:0]          r_prefetch;
    logic [7:0]          r_ctrl [8];
    logic [7:0]          r_status, n_status;
    logic [4:0]          r_last, n_last;
    logic                r_irq, n_irq;
    logic                r_out_valid;
    logic [7:0]          r_out_data, n_out_data;

    logic                accept;
    logic                mem_we;
    logic                fetch;
    logic [AW-1:0]       rd_addr;
    logic                reg_we;
    logic [2:0]          reg_sel;
    logic [7:0]          reg_val;
    logic                irq_en;

    assign o_ready     = (r_state == vpcp_pkg::ST_IDLE) && (!r_out_valid || i_ready);
    assign accept      = i_valid && o_ready;
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_interrupt = r_irq;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_pending  = r_pending;
        n_status   = r_status;
        n_last     = r_last;
        n_irq      = r_irq;
        n_out_data = 8'h00;
        mem_we     = 1'b0;
        fetch      = 1'b0;
        rd_addr    = r_addr;
        reg_we     = 1'b0;
        reg_sel    = i_data[2:0];
        reg_val    = r_addr[7:0] & vpcp_pkg::REG_MASK[i_data[2:0]];
        irq_en     = r_ctrl[1][vpcp_pkg::IRQ_ENABLE_BIT];

        if (accept) begin
            unique case (i_operation)
                vpcp_pkg::OP_DATA_WR: begin
                    mem_we    = 1'b1;
                    n_addr    = r_addr + AW'(1);
                    n_pending = 1'b0;
                end
                vpcp_pkg::OP_CTRL_WR: begin
                    if (r_pending) begin
                        n_addr    = {i_data[AW-9:0], r_addr[7:0]};
                        n_pending = 1'b0;
                        if (i_data[7]) begin
                            reg_we = 1'b1;
                            if (reg_sel == vpcp_pkg::IRQ_REG) begin
                                n_irq = r_status[vpcp_pkg::STAT_VBLANK_BIT]
                                        && reg_val[vpcp_pkg::IRQ_ENABLE_BIT];
                            end
                        end else if (!i_data[6]) begin
                            fetch   = 1'b1;
                            rd_addr = {i_data[AW-9:0], r_addr[7:0]};
                            n_addr  = {i_data[AW-9:0], r_addr[7:0]} + AW'(1);
                        end
                    end else begin
                        n_addr    = {r_addr[AW-1:8], i_data};
                        n_pending = 1'b1;
                    end
                end
                vpcp_pkg::OP_DATA_RD: begin
                    fetch      = 1'b1;
                    n_out_data = r_prefetch;
                    n_addr     = r_addr + AW'(1);
                    n_pending  = 1'b0;
                end
                vpcp_pkg::OP_STATUS_RD: begin
                    n_out_data = r_status;
                    n_status   = {3'b000, r_last};
                    n_irq      = 1'b0;
                    n_pending  = 1'b0;
                end
                vpcp_pkg::OP_VBLANK: begin
                    n_status[vpcp_pkg::STAT_VBLANK_BIT] = 1'b1;
                    n_irq = irq_en;
                end
                vpcp_pkg::OP_SPRITE: begin
                    if (!i_sprites_active) begin
                        n_last = vpcp_pkg::SPRITE_NONE;
                    end else begin
                        if (i_collision) begin
                            n_status[vpcp_pkg::STAT_COLLISION_BIT] = 1'b1;
                        end
                        n_last = i_sprite_index;
                        if (!r_status[vpcp_pkg::STAT_FIFTH_BIT]) begin
                            n_status[4:0] = i_sprite_index;
                            if (i_fifth_found && !r_status[vpcp_pkg::STAT_VBLANK_BIT]) begin
                                n_status[vpcp_pkg::STAT_FIFTH_BIT] = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            if (fetch) begin
                n_state = vpcp_pkg::ST_FILL;
            end
        end else if (r_state == vpcp_pkg::ST_FILL) begin
            n_state = vpcp_pkg::ST_IDLE;
        end
    end

    // video memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= i_data;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vpcp_pkg::ST_IDLE;
            r_addr      <= '0;
            r_pending   <= 1'b0;
            r_prefetch  <= 8'h00;
            r_ctrl      <= '{default: 8'h00};
            r_status    <= 8'h00;
            r_last      <= vpcp_pkg::SPRITE_NONE;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_data  <= 8'h00;
        end else begin
            r_state   <= n_state;
            r_addr    <= n_addr;
            r_pending <= n_pending;
            r_status  <= n_status;
            r_last    <= n_last;
            r_irq     <= n_irq;
            if (reg_we) begin
                r_ctrl[reg_sel] <= reg_val;
            end
            if (mem_we) begin
                r_prefetch <= i_data;
            end else if (r_state == vpcp_pkg::ST_FILL) begin
                r_prefetch <= r_mem_q;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                r_out_data  <= n_out_data;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/vpcp_checker.sv @@
// port-level checks for the video processor cpu port, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module vpcp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [2:0] i_operation,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_read_data,
    input wire logic       o_interrupt
);

    logic in_acc;
    assign in_acc = i_valid && o_ready;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_read_data) && $stable(o_interrupt))
        else $error("result changed while stalled");

    // only data and status reads return a byte
    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation != vpcp_pkg::OP_DATA_RD
               && i_operation != vpcp_pkg::OP_STATUS_RD
        |=> o_valid && o_read_data == 8'h00)
        else $error("nonzero read data on a transaction without a read");

    // interrupt moves only on control writes, status reads and vblank
    a_irq_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation != vpcp_pkg::OP_CTRL_WR
               && i_operation != vpcp_pkg::OP_STATUS_RD
               && i_operation != vpcp_pkg::OP_VBLANK
        |=> $stable(o_interrupt))
        else $error("interrupt changed on an unrelated transaction");

    // a data read holds off the next transaction while the read-ahead byte refills
    a_fill_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_operation == vpcp_pkg::OP_DATA_RD |=> !o_ready)
        else $error("transaction accepted during read-ahead refill");

endmodule

bind video_processor_cpu_port_top vpcp_checker u_vpcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_operation (i_operation),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_read_data (o_read_data),
    .o_interrupt (o_interrupt)
);

`default_nettype wire

@@ sim/video_processor_cpu_port_top_tb.sv @@
// testbench for the video processor cpu port: directed, random, back-to-back and stall tests against a port model
`timescale 1ns / 1ps

module video_processor_cpu_port_top_tb;

    localparam int VRAM_BYTES = 16384;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 700;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_level;
    } t_port_result;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [2:0] i_operation = '0;
    logic [7:0] i_data = '0;
    logic       i_sprites_active = 1'b0;
    logic       i_collision = 1'b0;
    logic       i_fifth_found = 1'b0;
    logic [4:0] i_sprite_index = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_read_data;
    logic       o_interrupt;

    // port model state
    logic [7:0]  vram_mirror [VRAM_BYTES];
    bit          vram_written [VRAM_BYTES];
    logic [13:0] written_addrs [$];
    logic [13:0] cur_addr = '0;
    bit          latch_pending = 1'b0;
    logic [7:0]  read_ahead = '0;
    logic [7:0]  ctrl_regs [8] = '{default: 8'h00};
    logic [7:0]  status = '0;
    logic [4:0]  last_sprite = vpcp_pkg::SPRITE_NONE;
    bit          irq = 1'b0;

    t_port_result expected_results [$];
    int error_count = 0;
    int items_sent = 0;
    bit source_gaps_on = 1'b1;
    bit sink_gaps_on = 1'b1;
    int sink_hold_cycles = 0;

    video_processor_cpu_port_top #(
        .VRAM_BYTES(VRAM_BYTES)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_data           (i_data),
        .i_sprites_active (i_sprites_active),
        .i_collision      (i_collision),
        .i_fifth_found    (i_fifth_found),
        .i_sprite_index   (i_sprite_index),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_read_data      (o_read_data),
        .o_interrupt      (o_interrupt)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [7:0] take_read_ahead();
        logic [7:0] old;
        old = read_ahead;
        read_ahead = vram_mirror[cur_addr];
        cur_addr = cur_addr + 14'd1;
        latch_pending = 1'b0;
        return old;
    endfunction

    function automatic void model_port_access(input logic [2:0] op, input logic [7:0] data,
                                              input logic act, input logic coll,
                                              input logic fifth, input logic [4:0] idx);
        t_port_result res;
        logic [2:0] r;
        res.read_data = '0;
        case (op)
            vpcp_pkg::OP_DATA_WR: begin
                if (!vram_written[cur_addr]) begin
                    vram_written[cur_addr] = 1'b1;
                    written_addrs.push_back(cur_addr);
                end
                vram_mirror[cur_addr] = data;
                cur_addr = cur_addr + 14'd1;
                read_ahead = data;
                latch_pending = 1'b0;
            end
            vpcp_pkg::OP_CTRL_WR: begin
                if (latch_pending) begin
                    cur_addr = {data[5:0], cur_addr[7:0]};
                    if (data[7]) begin
                        r = data[2:0];
                        ctrl_regs[r] = cur_addr[7:0] & vpcp_pkg::REG_MASK[r];
                        if (r == vpcp_pkg::IRQ_REG)
                            irq = status[vpcp_pkg::STAT_VBLANK_BIT]
                                  & ctrl_regs[1][vpcp_pkg::IRQ_ENABLE_BIT];
                    end else if (!data[6]) begin
                        void'(take_read_ahead());
                    end
                    latch_pending = 1'b0;
                end else begin
                    cur_addr[7:0] = data;
                    latch_pending = 1'b1;
                end
            end
            vpcp_pkg::OP_DATA_RD: res.read_data = take_read_ahead();
            vpcp_pkg::OP_STATUS_RD: begin
                res.read_data = status;
                status = {3'b000, last_sprite};
                irq = status[vpcp_pkg::STAT_VBLANK_BIT]
                      & ctrl_regs[1][vpcp_pkg::IRQ_ENABLE_BIT];
                latch_pending = 1'b0;
            end
            vpcp_pkg::OP_VBLANK: begin
                status[vpcp_pkg::STAT_VBLANK_BIT] = 1'b1;
                irq = status[vpcp_pkg::STAT_VBLANK_BIT]
                      & ctrl_regs[1][vpcp_pkg::IRQ_ENABLE_BIT];
            end
            vpcp_pkg::OP_SPRITE: begin
                if (!act) begin
                    last_sprite = vpcp_pkg::SPRITE_NONE;
                end else begin
                    if (coll)
                        status[vpcp_pkg::STAT_COLLISION_BIT] = 1'b1;
                    last_sprite = idx;
                    if (!status[vpcp_pkg::STAT_FIFTH_BIT]) begin
                        status[4:0] = idx;
                        if (fifth && !status[vpcp_pkg::STAT_VBLANK_BIT])
                            status[vpcp_pkg::STAT_FIFTH_BIT] = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        res.irq_level = irq;
        expected_results.push_back(res);
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [7:0] data, input logic act,
                             input logic coll, input logic fifth, input logic [4:0] idx);
        int gap;
        logic [13:0] next_addr;
        // never read a vram byte that has not been written
        if (op == vpcp_pkg::OP_DATA_RD && !vram_written[cur_addr])
            op = vpcp_pkg::OP_DATA_WR;
        if (op == vpcp_pkg::OP_CTRL_WR && latch_pending && data[7:6] == 2'b00) begin
            next_addr = {data[5:0], cur_addr[7:0]};
            if (!vram_written[next_addr])
                data[6] = 1'b1;
        end
        gap = source_gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_data <= data;
        i_sprites_active <= act;
        i_collision <= coll;
        i_fifth_found <= fifth;
        i_sprite_index <= idx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        model_port_access(op, data, act, coll, fifth, idx);
        items_sent++;
    endtask

    task automatic send_op(input logic [2:0] op, input logic [7:0] data);
        send_item(op, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
    endtask

    task automatic control_pair(input logic [7:0] low, input logic [7:0] high);
        if (latch_pending)
            send_op(vpcp_pkg::OP_STATUS_RD, 8'($urandom));
        send_op(vpcp_pkg::OP_CTRL_WR, low);
        send_op(vpcp_pkg::OP_CTRL_WR, high);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_scenario();
        logic [13:0] addr;
        logic [7:0]  low;
        logic [3:0]  filler;
        logic [2:0]  reg_sel;
        logic [2:0]  rop;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                addr = 14'($urandom);
                if ($urandom_range(0, 3) == 0)
                    addr = 14'h3ff8 + 14'($urandom_range(0, 7));
                control_pair(addr[7:0], {2'b01, addr[13:8]});
                repeat ($urandom_range(1, 8)) send_op(vpcp_pkg::OP_DATA_WR, 8'($urandom));
            end
            3, 4: begin
                if (written_addrs.size() > 0) begin
                    addr = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
                    control_pair(addr[7:0], {2'b00, addr[13:8]});
                    repeat ($urandom_range(1, 6)) send_op(vpcp_pkg::OP_DATA_RD, 8'($urandom));
                end
            end
            5: begin
                low = 8'($urandom);
                filler = 4'($urandom);
                reg_sel = 3'($urandom);
                control_pair(low, {1'b1, filler, reg_sel});
            end
            6: begin
                if ($urandom_range(0, 1))
                    send_op(vpcp_pkg::OP_VBLANK, 8'($urandom));
                send_op(vpcp_pkg::OP_STATUS_RD, 8'($urandom));
            end
            7: begin
                repeat ($urandom_range(1, 4))
                    send_item(vpcp_pkg::OP_SPRITE, 8'($urandom), $urandom_range(0, 3) != 0,
                              $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                              5'($urandom_range(0, 31)));
                if ($urandom_range(0, 1))
                    send_op(vpcp_pkg::OP_STATUS_RD, 8'($urandom));
            end
            8: begin
                repeat ($urandom_range(1, 3)) begin
                    rop = 3'($urandom_range(0, 5));
                    send_op(rop, 8'($urandom));
                end
            end
            default: begin
                // control write byte followed by a random operation
                send_op(vpcp_pkg::OP_CTRL_WR, 8'($urandom));
                rop = 3'($urandom_range(0, 5));
                send_op(rop, 8'($urandom));
            end
        endcase
    endtask

    task automatic test_directed_cases();
        send_op(vpcp_pkg::OP_STATUS_RD, 8'h00);
        control_pair(8'hff, 8'h81);
        send_op(vpcp_pkg::OP_VBLANK, 8'h00);
        send_op(vpcp_pkg::OP_STATUS_RD, 8'h00);
        control_pair(8'hff, 8'h7f);
        send_op(vpcp_pkg::OP_DATA_WR, 8'ha5);
        send_op(vpcp_pkg::OP_DATA_WR, 8'h5a);
        control_pair(8'hff, 8'h3f);
        send_op(vpcp_pkg::OP_DATA_RD, 8'h00);
        send_item(vpcp_pkg::OP_SPRITE, 8'h00, 1'b0, 1'b1, 1'b1, 5'd7);
        send_item(vpcp_pkg::OP_SPRITE, 8'h00, 1'b1, 1'b1, 1'b1, 5'd0);
        send_item(vpcp_pkg::OP_SPRITE, 8'h00, 1'b1, 1'b0, 1'b0, 5'd31);
        send_op(vpcp_pkg::OP_STATUS_RD, 8'h00);
        send_op(vpcp_pkg::OP_VBLANK, 8'h00);
        send_item(vpcp_pkg::OP_SPRITE, 8'h00, 1'b1, 1'b0, 1'b1, 5'd10);
        control_pair(8'h00, 8'h81);
        send_op(vpcp_pkg::OP_CTRL_WR, 8'h12);
        send_op(vpcp_pkg::OP_STATUS_RD, 8'h00);
        send_op(vpcp_pkg::OP_CTRL_WR, 8'h00);
        send_op(vpcp_pkg::OP_DATA_WR, 8'hff);
        send_op(OP_UNUSED_6, 8'hff);
        send_op(OP_UNUSED_7, 8'hff);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) random_scenario();
    endtask

    task automatic test_back_to_back();
        int stop_at;
        source_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        stop_at = items_sent + 80;
        while (items_sent < stop_at) random_scenario();
        source_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    task automatic test_output_stall();
        int stop_at;
        source_gaps_on = 1'b0;
        sink_hold_cycles = 200;
        stop_at = items_sent + 40;
        while (items_sent < stop_at) random_scenario();
        source_gaps_on = 1'b1;
    endtask

    initial begin : result_sink
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = sink_gaps_on ? $urandom_range(0, 5) : 0;
            if (sink_hold_cycles > 0) begin
                stall = sink_hold_cycles;
                sink_hold_cycles = 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_port_result exp_res;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected transaction: read_data %0h interrupt %0b",
                       o_read_data, o_interrupt);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_read_data !== exp_res.read_data) begin
                    $error("read_data mismatch: expected %0h, actual %0h",
                           exp_res.read_data, o_read_data);
                    error_count++;
                end
                if (o_interrupt !== exp_res.irq_level) begin
                    $error("interrupt mismatch: expected %0b, actual %0b",
                           exp_res.irq_level, o_interrupt);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        wait_idle();
        test_random_traffic();
        wait_idle();
        test_back_to_back();
        wait_idle();
        test_output_stall();
        wait_idle();
        if (expected_results.size() != 0) begin
            $error("%0d transactions never arrived", expected_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
